// ----- rtl/tdts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and keyword tables of the Tcl definition tag scanner.
// Used by every module in rtl/; depends on nothing.
package tdts_pkg;

   // line counter and output line field
   localparam int LINE_COUNT_BITS = 20;
   localparam int TAG_LINE_BITS   = 20;
   localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = {LINE_COUNT_BITS{1'b1}};

   // keyword matcher
   localparam int NUM_KW   = 11;
   localparam int POS_BITS = 4;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   typedef logic [NUM_KW-1:0]   kw_mask_type;
   typedef logic [POS_BITS-1:0] kw_pos_type;
   typedef logic [3:0]          kw_idx_type;

   localparam kw_mask_type ALL_KW_MASK   = 11'h7FF;
   localparam kw_mask_type FIRST_KW_MASK = 11'h2FF;

   localparam kw_idx_type KW_PROC       = 4'd0;
   localparam kw_idx_type KW_CLASS      = 4'd1;
   localparam kw_idx_type KW_ITCL_CLASS = 4'd2;
   localparam kw_idx_type KW_PUBLIC     = 4'd3;
   localparam kw_idx_type KW_PROTECTED  = 4'd4;
   localparam kw_idx_type KW_PRIVATE    = 4'd5;
   localparam kw_idx_type KW_METHOD     = 4'd6;
   localparam kw_idx_type KW_OO_CLASS   = 4'd7;
   localparam kw_idx_type KW_CREATE     = 4'd8;
   localparam kw_idx_type KW_NAMESPACE  = 4'd9;
   localparam kw_idx_type KW_EVAL       = 4'd10;

   // tag kinds
   typedef logic [1:0] tag_kind_type;
   localparam tag_kind_type KIND_CLASS     = 2'd0;
   localparam tag_kind_type KIND_METHOD    = 2'd1;
   localparam tag_kind_type KIND_PROCEDURE = 2'd2;
   localparam tag_kind_type KIND_NAMESPACE = 2'd3;

   // special bytes
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_HASH  = 8'd35;

   // one result item
   typedef struct packed {
      logic [7:0]               tag_byte;
      tag_kind_type             tag_kind;
      logic [TAG_LINE_BITS-1:0] tag_line;
      logic                     tag_last;
   } tag_item_type;

   // queue between scanner and output stage
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // keyword length
   function automatic kw_pos_type kw_len(input kw_idx_type k);
      kw_pos_type len;
      unique case (k)
         KW_PROC:       len = 4'd4;
         KW_CLASS:      len = 4'd5;
         KW_ITCL_CLASS: len = 4'd11;
         KW_PUBLIC:     len = 4'd6;
         KW_PROTECTED:  len = 4'd9;
         KW_PRIVATE:    len = 4'd7;
         KW_METHOD:     len = 4'd6;
         KW_OO_CLASS:   len = 4'd9;
         KW_CREATE:     len = 4'd6;
         KW_NAMESPACE:  len = 4'd9;
         KW_EVAL:       len = 4'd4;
         default:       len = 4'd0;
      endcase
      return len;
   endfunction

   // keyword byte at a position (text is right aligned in the vector)
   function automatic logic [7:0] kw_char(input kw_idx_type k, input kw_pos_type pos);
      logic [87:0] txt;
      kw_pos_type  len;
      kw_pos_type  sel;
      unique case (k)
         KW_PROC:       txt = 88'("proc");
         KW_CLASS:      txt = 88'("class");
         KW_ITCL_CLASS: txt = 88'("itcl::class");
         KW_PUBLIC:     txt = 88'("public");
         KW_PROTECTED:  txt = 88'("protected");
         KW_PRIVATE:    txt = 88'("private");
         KW_METHOD:     txt = 88'("method");
         KW_OO_CLASS:   txt = 88'("oo::class");
         KW_CREATE:     txt = 88'("create");
         KW_NAMESPACE:  txt = 88'("namespace");
         KW_EVAL:       txt = 88'("eval");
         default:       txt = '0;
      endcase
      len = kw_len(k);
      sel = len - pos - 4'd1;
      return txt[{sel, 3'b000} +: 8];
   endfunction

endpackage

// ----- rtl/tcl_definition_tag_scanner.sv -----
`timescale 1ns / 1ps
// Tcl definition tag scanner. Takes one script byte per cycle on req_ and
// streams tag name bytes (proc, class, itcl::class, method, public/protected/
// private method, oo::class create, namespace eval) on rsp_, with the tag kind
// on rsp_tuser and the final byte of each name marked by rsp_tlast. A byte is
// taken every cycle while the 4-entry tag queue has room; the next scanner state
// is combinational from the current state and the byte, so a steady 1 byte/cycle
// input rate is sustained as long as the result side keeps draining. Input
// stalls only once the queue has filled behind a stalled result. Each name byte
// is released when the next input byte arrives (to mark the last one); it then
// passes through the tag queue and the result register before it is valid on
// rsp_. Line numbers start at 1 and saturate.
// Depends on tdts_pkg, tdts_front, tdts_fifo, tdts_back.
module tcl_definition_tag_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] tag_byte, [27:8] tag_line, zero pad
   output logic [1:0]  rsp_tuser,   // [1:0] tag_kind
   output logic        rsp_tlast    // tag_last
);
   import tdts_pkg::*;

   logic          accept;
   logic          push, pop;
   tag_item_type  push_item, pop_item, rsp_item;
   fifo_stat_type stat;

   assign req_tready = !stat.full;
   assign accept     = req_tvalid && req_tready;

   tdts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .byte_in   (req_tdata),
      .push      (push),
      .push_item (push_item)
   );

   tdts_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (stat)
   );

   tdts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {4'b0000, rsp_item.tag_line, rsp_item.tag_byte};
   assign rsp_tuser = rsp_item.tag_kind;
   assign rsp_tlast = rsp_item.tag_last;

endmodule

// ----- rtl/tdts_front.sv -----
`timescale 1ns / 1ps
// Scanner front: takes script bytes, tracks line phase and keyword matching,
// and produces tag name bytes one byte late. Depends on tdts_pkg.
module tdts_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            byte_in,
   output logic                  push,
   output tdts_pkg::tag_item_type push_item
);
   import tdts_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD    = 3'd0,
      PH_FIRST   = 3'd1,
      PH_GAP_KW  = 3'd2,
      PH_KW2     = 3'd3,
      PH_GAP_TAG = 3'd4,
      PH_TAG     = 3'd5,
      PH_SKIP    = 3'd6
   } phase_type;

   phase_type                 phase_ff, phase_in;
   kw_mask_type               cand_ff, cand_in;
   kw_pos_type                pos_ff, pos_in;
   tag_kind_type              kind_ff, kind_in;
   logic [7:0]                held_ff, held_in;
   logic                      hvalid_ff, hvalid_in;
   logic [LINE_COUNT_BITS-1:0] line_ff, line_in;

   logic        is_nl, is_ws, is_nul;
   logic        emit, emit_last;
   kw_mask_type feed_src, feed_cand;
   kw_pos_type  feed_pos, feed_pos_next;
   logic        hit;
   kw_idx_type  hit_idx;

   // byte classes
   assign is_nl  = (byte_in == CHAR_NL);
   assign is_ws  = (byte_in == CHAR_SPACE) || ((byte_in >= CHAR_TAB) && (byte_in <= CHAR_CR));
   assign is_nul = (byte_in == CHAR_NUL);

   // one keyword feed step; a new word starts from position zero
   always_comb begin
      feed_src = (phase_ff == PH_LEAD) ? FIRST_KW_MASK : cand_ff;
      feed_pos = ((phase_ff == PH_LEAD) || (phase_ff == PH_GAP_KW)) ? '0 : pos_ff;
      for (int k = 0; k < NUM_KW; k++) begin
         feed_cand[k] = feed_src[k] && (feed_pos < kw_len(kw_idx_type'(k))) &&
                        (kw_char(kw_idx_type'(k), feed_pos) == byte_in);
      end
      feed_pos_next = (feed_pos == POS_MAX) ? feed_pos : feed_pos + 4'd1;
   end

   // full match of the word so far, lowest keyword first
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (cand_ff[k] && (kw_len(kw_idx_type'(k)) == pos_ff)) begin
            hit     = 1'b1;
            hit_idx = kw_idx_type'(k);
         end
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      cand_in   = cand_ff;
      pos_in    = pos_ff;
      kind_in   = kind_ff;
      held_in   = held_ff;
      hvalid_in = hvalid_ff;
      line_in   = line_ff;
      emit      = 1'b0;
      emit_last = 1'b0;

      unique case (phase_ff)
         PH_LEAD: begin
            if (is_nl) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
               phase_in = PH_LEAD;
            end else if (is_ws) begin
               phase_in = PH_LEAD;
            end else if (is_nul || (byte_in == CHAR_HASH)) begin
               phase_in = PH_SKIP;
            end else begin
               cand_in  = feed_cand;
               pos_in   = feed_pos_next;
               phase_in = PH_FIRST;
            end
         end
         PH_FIRST: begin
            if (is_nul) begin
               phase_in = PH_SKIP;
            end else if (!is_ws) begin
               cand_in = feed_cand;
               pos_in  = feed_pos_next;
            end else if (is_nl) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
               phase_in = PH_LEAD;
            end else if (!hit) begin
               phase_in = PH_SKIP;
            end else begin
               // first keyword decides the kind and what follows
               phase_in = PH_GAP_TAG;
               unique case (hit_idx)
                  KW_PROC: kind_in = KIND_PROCEDURE;
                  KW_CLASS, KW_ITCL_CLASS: kind_in = KIND_CLASS;
                  KW_METHOD: kind_in = KIND_METHOD;
                  KW_PUBLIC, KW_PROTECTED, KW_PRIVATE: begin
                     kind_in  = KIND_METHOD;
                     cand_in  = kw_mask_type'(1) << KW_METHOD;
                     phase_in = PH_GAP_KW;
                  end
                  KW_OO_CLASS: begin
                     kind_in  = KIND_CLASS;
                     cand_in  = kw_mask_type'(1) << KW_CREATE;
                     phase_in = PH_GAP_KW;
                  end
                  KW_NAMESPACE: begin
                     kind_in  = KIND_NAMESPACE;
                     cand_in  = kw_mask_type'(1) << KW_EVAL;
                     phase_in = PH_GAP_KW;
                  end
                  default: phase_in = PH_SKIP;
               endcase
            end
         end
         PH_GAP_KW: begin
            if (is_nl) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
               phase_in = PH_LEAD;
            end else if (is_ws) begin
               phase_in = PH_GAP_KW;
            end else if (is_nul) begin
               phase_in = PH_SKIP;
            end else begin
               cand_in  = feed_cand;
               pos_in   = feed_pos_next;
               phase_in = PH_KW2;
            end
         end
         PH_KW2: begin
            if (is_nl) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
               phase_in = PH_LEAD;
            end else if (is_nul) begin
               phase_in = PH_SKIP;
            end else if (is_ws) begin
               phase_in = hit ? PH_GAP_TAG : PH_SKIP;
            end else begin
               cand_in = feed_cand;
               pos_in  = feed_pos_next;
            end
         end
         PH_GAP_TAG: begin
            if (is_nl) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
               phase_in = PH_LEAD;
            end else if (is_ws) begin
               phase_in = PH_GAP_TAG;
            end else if (is_nul) begin
               phase_in = PH_SKIP;
            end else begin
               held_in   = byte_in;
               hvalid_in = 1'b1;
               phase_in  = PH_TAG;
            end
         end
         PH_TAG: begin
            if (!is_ws && !is_nul) begin
               emit      = hvalid_ff;
               held_in   = byte_in;
               hvalid_in = 1'b1;
            end else begin
               emit      = hvalid_ff;
               emit_last = 1'b1;
               hvalid_in = 1'b0;
               if (is_nl) begin
                  if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
                  phase_in = PH_LEAD;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         default: begin
            // rest of line ignored
            if (is_nl) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
               phase_in = PH_LEAD;
            end else begin
               phase_in = PH_SKIP;
            end
         end
      endcase
   end

   // emitted item uses the state before this byte
   assign push               = accept && emit;
   assign push_item.tag_byte = held_ff;
   assign push_item.tag_kind = kind_ff;
   assign push_item.tag_line = TAG_LINE_BITS'(line_ff);
   assign push_item.tag_last = emit_last;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         cand_ff   <= ALL_KW_MASK;
         pos_ff    <= '0;
         kind_ff   <= KIND_CLASS;
         held_ff   <= '0;
         hvalid_ff <= 1'b0;
         line_ff   <= LINE_COUNT_BITS'(1);
      end else if (accept) begin
         phase_ff  <= phase_in;
         cand_ff   <= cand_in;
         pos_ff    <= pos_in;
         kind_ff   <= kind_in;
         held_ff   <= held_in;
         hvalid_ff <= hvalid_in;
         line_ff   <= line_in;
      end
   end

endmodule

// ----- rtl/tdts_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of tag items between scanner front and output stage.
// Depends on tdts_pkg.
module tdts_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tdts_pkg::tag_item_type push_item,
   input  logic                   pop,
   output tdts_pkg::tag_item_type pop_item,
   output tdts_pkg::fifo_stat_type stat
);
   import tdts_pkg::*;

   tag_item_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_item   = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

   // no write into a full queue unless an item is read in the same cycle, no read from an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push || pop)
      else $error("tag queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> !pop)
      else $error("tag queue underflow");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("tag queue count did not advance on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == FIFO_PTR_BITS'(count_ff))
      else $error("tag queue pointers disagree with count");

endmodule

// ----- rtl/tdts_back.sv -----
`timescale 1ns / 1ps
// Output stage: pulls tag items from the queue into the result register
// and drives the result stream. Depends on tdts_pkg.
module tdts_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tdts_pkg::fifo_stat_type stat,
   input  tdts_pkg::tag_item_type  pop_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tdts_pkg::tag_item_type  rsp_item
);
   import tdts_pkg::*;

   logic         valid_ff, valid_in;
   tag_item_type item_ff;

   // load whenever the register is free or being drained
   assign pop      = !stat.empty && (!valid_ff || rsp_ready);
   assign valid_in = pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) item_ff <= pop_item;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
